/* hw/rtl/jqufc_pkg.sv */
package jqufc_pkg;

    // queue geometry
    localparam int DEPTH = 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    typedef logic [AW-1:0] t_ptr;
    typedef logic [CW-1:0] t_cnt;

    // operation codes
    typedef enum logic [1:0] {
        KIND_ENQ    = 2'd0,
        KIND_DEQ    = 2'd1,
        KIND_CANCEL = 2'd2,
        KIND_RSVD   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] pages;
        logic [7:0]  copies;
        logic        urgent;
    } t_entry;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] job_id;
        logic [15:0] page_total;
        logic [7:0]  copy_count;
        logic        urgent;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [15:0] out_id;
        logic [15:0] out_pages;
        logic [7:0]  out_copies;
        logic        out_urgent;
        logic [15:0] head_id;
        logic [15:0] head_pages;
        logic [7:0]  head_copies;
        logic        head_urgent;
        logic [4:0]  entry_count;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEQ_RD,
        ST_DEQ_CAP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_HEAD_RD,
        ST_HEAD_CAP
    } t_state;

    // physical slot of logical position off, counted from base, with wrap
    function automatic t_ptr ptr_add(input t_ptr base, input t_cnt off);
        logic [AW:0] sum;
        sum = {1'b0, base} + (AW+1)'(off);
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // one slot toward the front, with wrap
    function automatic t_ptr ptr_dec(input t_ptr base);
        t_ptr res;
        if (base == '0) begin
            res = AW'(DEPTH - 1);
        end else begin
            res = base - AW'(1);
        end
        return res;
    endfunction

endpackage

/* hw/rtl/jqufc_if.sv */
interface jqufc_req_if import jqufc_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface jqufc_rsp_if import jqufc_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/job_queue_urgent_front_cancel.sv */
// Bounded print job queue of DEPTH entries (id, pages, copies, urgent flag) kept
// as a ring in one single-port-read, single-port-write memory with a head pointer
// and a fill count. An urgent enqueue moves the head back one slot and writes
// there, a normal enqueue writes behind the tail, and a dequeue reads the head and
// advances it. Cancel walks the ring from the front, one read and one compare per
// entry, and on a hit closes the gap by copying each later entry one slot forward,
// one read and one write per entry. Every result carries the front entry and the
// count after the operation, read back from the memory at the end. One item is in
// work at a time and input ready is low until its result is formed. Enqueue, an
// unknown kind and any operation on an empty queue go straight to the front read,
// dequeue first reads and removes the head, and cancel scans and then shifts, both
// limited by the single memory read port. The result sits in an output register,
// so the next item is accepted while it waits to be taken; that next item then
// holds in its last step until the register is free. No clearing pass after reset:
// the memory is read only below the fill count or at an empty head, shown as zeros.
module job_queue_urgent_front_cancel import jqufc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    jqufc_req_if.sink         i_req,
    jqufc_rsp_if.source       o_rsp
);

    // entry storage, no reset
    t_entry mem [DEPTH];
    t_entry r_rdata;

    // sequencer and queue control
    t_state r_state, n_state;
    t_ptr   r_head,  n_head;
    t_cnt   r_count, n_count;
    t_cnt   r_idx,   n_idx;

    // item in work
    t_req   r_req,   n_req;
    logic   r_ok,    n_ok;
    t_entry r_out,   n_out;

    // result register
    t_rsp   r_rsp;
    logic   r_rsp_valid;

    // memory port controls
    logic   rd_en;
    t_ptr   rd_addr;
    logic   wr_en;
    t_ptr   wr_addr;
    t_entry wr_data;
    logic   load_rsp;

    logic   in_acc;
    logic   full;
    logic   empty;
    logic   hit;
    logic   scan_last;
    logic   shift_last;
    t_kind  in_kind;

    assign i_req.ready = (r_state == ST_IDLE);
    assign in_acc      = i_req.valid && i_req.ready;
    assign in_kind     = t_kind'(i_req.data.kind);
    assign full        = (r_count == CW'(DEPTH));
    assign empty       = (r_count == '0);
    // scan compare sees the entry at logical position r_idx
    assign hit         = (r_rdata.id == r_req.job_id);
    assign scan_last   = ((r_idx + t_cnt'(1)) == r_count);
    assign shift_last  = ((r_idx + t_cnt'(2)) == r_count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_kind)
                        KIND_DEQ:    n_state = empty ? ST_HEAD_RD : ST_DEQ_RD;
                        KIND_CANCEL: n_state = empty ? ST_HEAD_RD : ST_SCAN_RD;
                        default:     n_state = ST_HEAD_RD;
                    endcase
                end
            end
            ST_DEQ_RD:   n_state = ST_DEQ_CAP;
            ST_DEQ_CAP:  n_state = ST_HEAD_RD;
            ST_SCAN_RD:  n_state = ST_SCAN_CMP;
            ST_SCAN_CMP: begin
                if (hit) begin
                    // removing the last entry needs no shift
                    n_state = scan_last ? ST_HEAD_RD : ST_SHIFT_RD;
                end else begin
                    n_state = scan_last ? ST_HEAD_RD : ST_SCAN_RD;
                end
            end
            ST_SHIFT_RD: n_state = ST_SHIFT_WR;
            ST_SHIFT_WR: n_state = shift_last ? ST_HEAD_RD : ST_SHIFT_RD;
            ST_HEAD_RD:  n_state = ST_HEAD_CAP;
            ST_HEAD_CAP: begin
                // hold until the result register is free
                if (!r_rsp_valid || o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_idx    = r_idx;
        n_req    = r_req;
        n_ok     = r_ok;
        n_out    = r_out;
        rd_en    = 1'b0;
        rd_addr  = r_head;
        wr_en    = 1'b0;
        wr_addr  = r_head;
        wr_data  = r_rdata;
        load_rsp = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_req = i_req.data;
                    n_ok  = 1'b0;
                    n_out = '0;
                    n_idx = '0;
                    if (in_kind == KIND_ENQ && !full) begin
                        wr_en   = 1'b1;
                        wr_data = '{id:     i_req.data.job_id,
                                    pages:  i_req.data.page_total,
                                    copies: i_req.data.copy_count,
                                    urgent: i_req.data.urgent};
                        if (i_req.data.urgent) begin
                            // newest urgent job becomes the front
                            wr_addr = ptr_dec(r_head);
                            n_head  = wr_addr;
                        end else begin
                            wr_addr = ptr_add(r_head, r_count);
                        end
                        n_count = r_count + t_cnt'(1);
                        n_ok    = 1'b1;
                    end
                end
            end
            ST_DEQ_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_head;
            end
            ST_DEQ_CAP: begin
                n_out   = r_rdata;
                n_ok    = 1'b1;
                n_head  = ptr_add(r_head, t_cnt'(1));
                n_count = r_count - t_cnt'(1);
            end
            ST_SCAN_RD: begin
                rd_en   = 1'b1;
                rd_addr = ptr_add(r_head, r_idx);
            end
            ST_SCAN_CMP: begin
                if (hit) begin
                    n_ok = 1'b1;
                    if (scan_last) begin
                        n_count = r_count - t_cnt'(1);
                    end
                end else begin
                    n_idx = r_idx + t_cnt'(1);
                end
            end
            ST_SHIFT_RD: begin
                rd_en   = 1'b1;
                rd_addr = ptr_add(r_head, r_idx + t_cnt'(1));
            end
            ST_SHIFT_WR: begin
                // move entry idx+1 into the gap at idx
                wr_en   = 1'b1;
                wr_addr = ptr_add(r_head, r_idx);
                wr_data = r_rdata;
                n_idx   = r_idx + t_cnt'(1);
                if (shift_last) begin
                    n_count = r_count - t_cnt'(1);
                end
            end
            ST_HEAD_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_head;
            end
            ST_HEAD_CAP: begin
                load_rsp = !r_rsp_valid || o_rsp.ready;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (load_rsp) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_ok  <= n_ok;
        r_out <= n_out;
        if (load_rsp) begin
            r_rsp.ok          <= r_ok;
            r_rsp.out_id      <= r_out.id;
            r_rsp.out_pages   <= r_out.pages;
            r_rsp.out_copies  <= r_out.copies;
            r_rsp.out_urgent  <= r_out.urgent;
            // empty queue shows a zero front entry
            r_rsp.head_id     <= empty ? '0 : r_rdata.id;
            r_rsp.head_pages  <= empty ? '0 : r_rdata.pages;
            r_rsp.head_copies <= empty ? '0 : r_rdata.copies;
            r_rsp.head_urgent <= empty ? 1'b0 : r_rdata.urgent;
            r_rsp.entry_count <= 5'(r_count);
        end
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

endmodule

/* hw/rtl/jqufc_checker.sv */
module jqufc_checker import jqufc_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input t_rsp i_rsp
);

    // no result right out of reset
    a_no_rsp_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_rsp_valid)
        else $error("result valid right after reset");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("input ready right after an accepted item");

    // failed operations return no entry
    a_fail_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp.ok) |-> (i_rsp.out_id == '0 && i_rsp.out_pages == '0
            && i_rsp.out_copies == '0 && !i_rsp.out_urgent))
        else $error("failed result carries entry data");

    // empty queue shows a zero front entry
    a_empty_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp.entry_count == '0) |-> (i_rsp.head_id == '0
            && i_rsp.head_pages == '0 && i_rsp.head_copies == '0 && !i_rsp.head_urgent))
        else $error("empty queue shows a front entry");

endmodule

bind job_queue_urgent_front_cancel jqufc_checker u_jqufc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp       (o_rsp.data)
);
